// File: rtl/hsva_pkg.sv
package hsva_pkg;

    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 4 * BYTE_W;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

endpackage

// File: rtl/hsva_in_if.sv
interface hsva_in_if #(
    parameter int FRAC_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [FRAC_BITS-1:0]        hue_fraction;
    logic signed [FRAC_BITS+1:0] sat_level;
    logic signed [FRAC_BITS+1:0] bright_level;
    logic signed [FRAC_BITS+1:0] alpha_level;

    modport source (
        output valid, hue_fraction, sat_level, bright_level, alpha_level,
        input  ready
    );
    modport sink (
        input  valid, hue_fraction, sat_level, bright_level, alpha_level,
        output ready
    );
endinterface

// File: rtl/rgba_out_if.sv
interface rgba_out_if;
    logic                          valid;
    logic                          ready;
    logic [hsva_pkg::COLOR_W-1:0]  packed_color;

    modport source (
        output valid, packed_color,
        input  ready
    );
    modport sink (
        input  valid, packed_color,
        output ready
    );
endinterface

// File: rtl/hsva_to_rgba8888.sv
// Channel   Dir  Handshake     Payload
// i_hsva    in   valid/ready   hue_fraction, sat_level, bright_level, alpha_level
// o_rgba    out  valid/ready   packed_color (R 31..24, G 23..16, B 15..8, A 7..0)
//
// One request per cycle sustained while o_rgba is ready; a request passes through the front, ramp and pack registers.
// Stages: clamp and hue*6, three multiplies (p, s*f, s*(1-f)), two multiplies
// (q, t), then sector select and byte scaling into the output register.
// Synchronous active-low reset clears only the stage valid bits.
// Each stage refills whenever it is empty or its successor takes its request.
module hsva_to_rgba8888 #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsva_in_if.sink     i_hsva,
    rgba_out_if.source  o_rgba
);

    logic                 w_vld_f;
    logic                 w_rdy_f;
    logic [FRAC_BITS:0]   w_sat_f;
    logic [FRAC_BITS:0]   w_val_f;
    logic [FRAC_BITS:0]   w_alp_f;
    logic [FRAC_BITS-1:0] w_frac_f;
    hsva_pkg::t_sector    w_sec_f;

    logic                 w_vld_r;
    logic                 w_rdy_r;
    logic [FRAC_BITS:0]   w_p_r;
    logic [FRAC_BITS:0]   w_q_r;
    logic [FRAC_BITS:0]   w_t_r;
    logic [FRAC_BITS:0]   w_val_r;
    logic [FRAC_BITS:0]   w_alp_r;
    hsva_pkg::t_sector    w_sec_r;

    hsva_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_hsva.valid),
        .o_rdy   (i_hsva.ready),
        .i_hue   (i_hsva.hue_fraction),
        .i_sat   (i_hsva.sat_level),
        .i_val   (i_hsva.bright_level),
        .i_alp   (i_hsva.alpha_level),
        .o_vld   (w_vld_f),
        .i_rdy   (w_rdy_f),
        .o_sat   (w_sat_f),
        .o_val   (w_val_f),
        .o_alp   (w_alp_f),
        .o_frac  (w_frac_f),
        .o_sec   (w_sec_f)
    );

    hsva_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_f),
        .o_rdy   (w_rdy_f),
        .i_sat   (w_sat_f),
        .i_val   (w_val_f),
        .i_alp   (w_alp_f),
        .i_frac  (w_frac_f),
        .i_sec   (w_sec_f),
        .o_vld   (w_vld_r),
        .i_rdy   (w_rdy_r),
        .o_p     (w_p_r),
        .o_q     (w_q_r),
        .o_t     (w_t_r),
        .o_val   (w_val_r),
        .o_alp   (w_alp_r),
        .o_sec   (w_sec_r)
    );

    hsva_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_r),
        .o_rdy   (w_rdy_r),
        .i_p     (w_p_r),
        .i_q     (w_q_r),
        .i_t     (w_t_r),
        .i_val   (w_val_r),
        .i_alp   (w_alp_r),
        .i_sec   (w_sec_r),
        .o_vld   (o_rgba.valid),
        .i_rdy   (o_rgba.ready),
        .o_color (o_rgba.packed_color)
    );

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rgba.valid)
        else $error("output valid after reset");

    a_accept_loads_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_hsva.valid && i_hsva.ready) |=> w_vld_f)
        else $error("accepted request not captured");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_f && !w_rdy_f) |=> (w_vld_f && $stable(w_sat_f) && $stable(w_frac_f)))
        else $error("front stage lost a stalled request");

endmodule

// File: rtl/hsva_front.sv
module hsva_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [FRAC_BITS-1:0]        i_hue,
    input  logic signed [FRAC_BITS+1:0] i_sat,
    input  logic signed [FRAC_BITS+1:0] i_val,
    input  logic signed [FRAC_BITS+1:0] i_alp,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [FRAC_BITS:0]          o_sat,
    output logic [FRAC_BITS:0]          o_val,
    output logic [FRAC_BITS:0]          o_alp,
    output logic [FRAC_BITS-1:0]        o_frac,
    output hsva_pkg::t_sector           o_sec
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [FRAC_BITS:0] clamp_lvl(input logic [FRAC_BITS+1:0] x);
        logic [FRAC_BITS:0] y;
        if (x[FRAC_BITS+1]) begin
            y = '0;
        end else if (x[FRAC_BITS]) begin
            y = ONE;
        end else begin
            y = {1'b0, x[FRAC_BITS-1:0]};
        end
        return y;
    endfunction

    logic [FRAC_BITS+2:0] w_h6;
    logic                 w_load;

    logic                 r_vld;
    logic [FRAC_BITS:0]   r_sat;
    logic [FRAC_BITS:0]   r_val;
    logic [FRAC_BITS:0]   r_alp;
    logic [FRAC_BITS-1:0] r_frac;
    hsva_pkg::t_sector    r_sec;

    // hue * 6 = hue * 4 + hue * 2
    assign w_h6   = ({3'b000, i_hue} << 2) + ({3'b000, i_hue} << 1);
    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sat  <= clamp_lvl(i_sat);
            r_val  <= clamp_lvl(i_val);
            r_alp  <= clamp_lvl(i_alp);
            r_frac <= w_h6[FRAC_BITS-1:0];
            r_sec  <= hsva_pkg::t_sector'(w_h6[FRAC_BITS+2:FRAC_BITS]);
        end
    end

    assign o_vld  = r_vld;
    assign o_sat  = r_sat;
    assign o_val  = r_val;
    assign o_alp  = r_alp;
    assign o_frac = r_frac;
    assign o_sec  = r_sec;

endmodule

// File: rtl/hsva_ramp.sv
module hsva_ramp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_val,
    input  logic [FRAC_BITS:0]   i_alp,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  hsva_pkg::t_sector    i_sec,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output logic [FRAC_BITS:0]   o_p,
    output logic [FRAC_BITS:0]   o_q,
    output logic [FRAC_BITS:0]   o_t,
    output logic [FRAC_BITS:0]   o_val,
    output logic [FRAC_BITS:0]   o_alp,
    output hsva_pkg::t_sector    o_sec
);

    localparam int LW = FRAC_BITS + 1;
    localparam int PW = 2 * LW;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // stage A: p, s*f, s*(1-f)
    logic [LW-1:0] w_inv_s;
    logic [LW-1:0] w_inv_f;
    logic [PW-1:0] w_pp;
    logic [PW-1:0] w_sf;
    logic [PW-1:0] w_s1f;
    logic          w_rdy_a;

    logic              r_vld_a;
    logic [LW-1:0]     r_p_a;
    logic [LW-1:0]     r_sf_a;
    logic [LW-1:0]     r_s1f_a;
    logic [LW-1:0]     r_val_a;
    logic [LW-1:0]     r_alp_a;
    hsva_pkg::t_sector r_sec_a;

    // stage B: q, t
    logic [PW-1:0] w_qq;
    logic [PW-1:0] w_tt;
    logic          w_rdy_b;

    logic              r_vld_b;
    logic [LW-1:0]     r_p_b;
    logic [LW-1:0]     r_q_b;
    logic [LW-1:0]     r_t_b;
    logic [LW-1:0]     r_val_b;
    logic [LW-1:0]     r_alp_b;
    hsva_pkg::t_sector r_sec_b;

    assign w_inv_s = ONE - i_sat;
    assign w_inv_f = ONE - {1'b0, i_frac};
    assign w_pp    = {{LW{1'b0}}, i_val} * {{LW{1'b0}}, w_inv_s};
    assign w_sf    = {{LW{1'b0}}, i_sat} * {{(LW+1){1'b0}}, i_frac};
    assign w_s1f   = {{LW{1'b0}}, i_sat} * {{LW{1'b0}}, w_inv_f};

    assign w_rdy_b = !r_vld_b || i_rdy;
    assign w_rdy_a = !r_vld_a || w_rdy_b;
    assign o_rdy   = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_vld_a <= i_vld;
            end
            if (w_rdy_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && w_rdy_a) begin
            r_p_a   <= w_pp[2*FRAC_BITS:FRAC_BITS];
            r_sf_a  <= w_sf[2*FRAC_BITS:FRAC_BITS];
            r_s1f_a <= w_s1f[2*FRAC_BITS:FRAC_BITS];
            r_val_a <= i_val;
            r_alp_a <= i_alp;
            r_sec_a <= i_sec;
        end
    end

    assign w_qq = {{LW{1'b0}}, r_val_a} * {{LW{1'b0}}, LW'(ONE - r_sf_a)};
    assign w_tt = {{LW{1'b0}}, r_val_a} * {{LW{1'b0}}, LW'(ONE - r_s1f_a)};

    always_ff @(posedge i_clk) begin
        if (r_vld_a && w_rdy_b) begin
            r_p_b   <= r_p_a;
            r_q_b   <= w_qq[2*FRAC_BITS:FRAC_BITS];
            r_t_b   <= w_tt[2*FRAC_BITS:FRAC_BITS];
            r_val_b <= r_val_a;
            r_alp_b <= r_alp_a;
            r_sec_b <= r_sec_a;
        end
    end

    assign o_vld = r_vld_b;
    assign o_p   = r_p_b;
    assign o_q   = r_q_b;
    assign o_t   = r_t_b;
    assign o_val = r_val_b;
    assign o_alp = r_alp_b;
    assign o_sec = r_sec_b;

endmodule

// File: rtl/hsva_pack.sv
module hsva_pack #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_rdy,
    input  logic [FRAC_BITS:0]           i_p,
    input  logic [FRAC_BITS:0]           i_q,
    input  logic [FRAC_BITS:0]           i_t,
    input  logic [FRAC_BITS:0]           i_val,
    input  logic [FRAC_BITS:0]           i_alp,
    input  hsva_pkg::t_sector            i_sec,
    output logic                         o_vld,
    input  logic                         i_rdy,
    output logic [hsva_pkg::COLOR_W-1:0] o_color
);

    localparam int BW = hsva_pkg::BYTE_W;

    // floor(x * 255 / ONE), x * 255 = x * 256 - x
    function automatic logic [BW-1:0] to_byte(input logic [FRAC_BITS:0] x);
        logic [FRAC_BITS+BW:0] m;
        m = {x, {BW{1'b0}}} - {{BW{1'b0}}, x};
        return m[FRAC_BITS+BW-1:FRAC_BITS];
    endfunction

    logic [FRAC_BITS:0] w_r;
    logic [FRAC_BITS:0] w_g;
    logic [FRAC_BITS:0] w_b;

    logic                         r_vld;
    logic [hsva_pkg::COLOR_W-1:0] r_color;

    always_comb begin
        case (i_sec)
            hsva_pkg::SEC_0: begin
                w_r = i_val; w_g = i_t;   w_b = i_p;
            end
            hsva_pkg::SEC_1: begin
                w_r = i_q;   w_g = i_val; w_b = i_p;
            end
            hsva_pkg::SEC_2: begin
                w_r = i_p;   w_g = i_val; w_b = i_t;
            end
            hsva_pkg::SEC_3: begin
                w_r = i_p;   w_g = i_q;   w_b = i_val;
            end
            hsva_pkg::SEC_4: begin
                w_r = i_t;   w_g = i_p;   w_b = i_val;
            end
            default: begin
                w_r = i_val; w_g = i_p;   w_b = i_q;
            end
        endcase
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && o_rdy) begin
            r_color <= {to_byte(w_r), to_byte(w_g), to_byte(w_b), to_byte(i_alp)};
        end
    end

    assign o_vld   = r_vld;
    assign o_color = r_color;

endmodule
